// ===== rtl/isim_pkg.sv =====
// Shared widths, register indexes, commands and decision record for the
// Metropolis spin update block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isim_pkg;

  localparam int ROW_W      = 6;
  localparam int UNI_W      = 32;
  localparam int TH_W       = 32;
  localparam int DE_W       = 5;
  localparam int MAG_W      = 14;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_THRESH_FOUR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_EIGHT = CFG_IDX_W'(1);

  localparam logic [TH_W-1:0] TH_FOUR_RESET  = 32'd1580030168;
  localparam logic [TH_W-1:0] TH_EIGHT_RESET = 32'd581260615;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic signed [DE_W-1:0] DE_ZERO  = 5'sd0;
  localparam logic signed [DE_W-1:0] DE_FOUR  = 5'sd4;
  localparam logic signed [DE_W-1:0] DE_EIGHT = 5'sd8;

  typedef struct packed {
    logic signed [DE_W-1:0] de;
    logic                   accept;
  } decide_t;

endpackage
`default_nettype wire

// ===== rtl/isim_channels.sv =====
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on isim_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface isim_req_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [isim_pkg::ROW_W-1:0] row;
  logic [isim_pkg::ROW_W-1:0] col;
  logic                      spin_value;
  logic [isim_pkg::UNI_W-1:0] uniform;

  modport source (output valid, cmd, row, col, spin_value, uniform, input ready);
  modport sink (input valid, cmd, row, col, spin_value, uniform, output ready);
endinterface

interface isim_res_if;
  logic                             valid;
  logic                             ready;
  logic                             spin_after;
  logic                             flipped;
  logic signed [isim_pkg::DE_W-1:0]  energy_change;
  logic signed [isim_pkg::MAG_W-1:0] magnetization;

  modport source (output valid, spin_after, flipped, energy_change, magnetization,
                  input ready);
  modport sink (input valid, spin_after, flipped, energy_change, magnetization,
                output ready);
endinterface

interface isim_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [isim_pkg::CFG_IDX_W-1:0]  index;
  logic [isim_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/isim_row_mem.sv =====
// Lattice row memory: one row of spins per entry, one write port and two
// registered read ports with write-through bypass. No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module isim_row_mem #(
  parameter int SIDE = 64,
  parameter int IW   = 6
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IW-1:0]   waddr,
  input  wire logic [SIDE-1:0] wdata,
  input  wire logic            re_a,
  input  wire logic [IW-1:0]   raddr_a,
  output logic      [SIDE-1:0] rdata_a,
  input  wire logic            re_b,
  input  wire logic [IW-1:0]   raddr_b,
  output logic      [SIDE-1:0] rdata_b
);

  logic [SIDE-1:0] mem [SIDE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      if (we && waddr == raddr_a) begin
        rdata_a <= wdata;
      end else begin
        rdata_a <= mem[raddr_a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re_b) begin
      if (we && waddr == raddr_b) begin
        rdata_b <= wdata;
      end else begin
        rdata_b <= mem[raddr_b];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/isim_decide.sv =====
// Energy change and Metropolis acceptance for one site and its four neighbors.
// Depends on isim_pkg for widths and the decision record.
`timescale 1ns / 1ps
`default_nettype none
module isim_decide (
  input  wire logic                       s,
  input  wire logic                       left,
  input  wire logic                       right,
  input  wire logic                       up,
  input  wire logic                       down,
  input  wire logic [isim_pkg::UNI_W-1:0] uniform,
  input  wire logic [isim_pkg::TH_W-1:0]  th_four,
  input  wire logic [isim_pkg::TH_W-1:0]  th_eight,
  output isim_pkg::decide_t               dec
);
  import isim_pkg::*;

  logic [2:0]      n_up;
  logic [DE_W-1:0] de_plus;
  logic [DE_W-1:0] de_u;

  always_comb begin
    n_up    = 3'({2'b00, left} + {2'b00, right} + {2'b00, up} + {2'b00, down});
    // dE for s = +1 is 4*n - 8; negate for s = -1
    de_plus = DE_W'({n_up, 2'b00}) - DE_W'(8);
    de_u    = s ? de_plus : (DE_W'(0) - de_plus);
    dec.de  = signed'(de_u);
    if (dec.de[DE_W-1] || dec.de == DE_ZERO) begin
      dec.accept = 1'b1;
    end else if (dec.de == DE_FOUR) begin
      dec.accept = uniform < th_four;
    end else begin
      dec.accept = uniform < th_eight;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ising_metropolis_spin_update.sv =====
// Top level of the Metropolis spin update block: sequencer, row memory and
// acceptance logic. Depends on isim_pkg, isim_channels, isim_row_mem, isim_decide.
//
// Keeps a SIDE x SIDE periodic lattice of spins in a row-wide memory with two
// read ports. After reset a clearing pass sets every spin to +1, one row per
// cycle; no request is accepted during it (configuration writes are taken
// throughout). An update request reads its rows in turn: rows r and r-1 are read
// at acceptance, row r+1 in the next cycle, and the decision and the write-back
// of row r follow, overlapping the next request's first read. A load request
// skips the second read since it needs only row r. Results wait in an
// output register; a stalled result holds the block after the current request.
`timescale 1ns / 1ps
`default_nettype none
module ising_metropolis_spin_update #(
  parameter int SIDE = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  isim_req_if.sink  request,
  isim_res_if.source result,
  isim_cfg_if.sink  cfg
);
  import isim_pkg::*;

  localparam int IW = $clog2(SIDE);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RD2   = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  localparam logic [IW-1:0]    LAST_IDX  = IW'(SIDE - 1);
  localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(SIDE * SIDE);
  localparam logic [MAG_W-1:0] MAG_STEP  = MAG_W'(2);

  typedef logic [IW-1:0] mod_tab_t [2**ROW_W];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    for (int i = 0; i < 2**ROW_W; i++) begin
      t[i] = IW'(i % SIDE);
    end
    return t;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IW-1:0]    clr_cnt;
  logic [TH_W-1:0]  th_four;
  logic [TH_W-1:0]  th_eight;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] mag_next;

  logic             cmd_q;
  logic [IW-1:0]    row_q;
  logic [IW-1:0]    col_q;
  logic             spin_q;
  logic [UNI_W-1:0] uni_q;
  logic             up_bit;

  logic [IW-1:0]    req_row;
  logic [IW-1:0]    req_up;
  logic [IW-1:0]    row_dn;
  logic [IW-1:0]    col_l;
  logic [IW-1:0]    col_r;

  logic             accept;
  logic             exec_go;
  logic             clearing;

  logic             we;
  logic [IW-1:0]    waddr;
  logic [SIDE-1:0]  wdata;
  logic [SIDE-1:0]  wrow;
  logic             re_b;
  logic [IW-1:0]    raddr_b;
  logic [SIDE-1:0]  rd_a;
  logic [SIDE-1:0]  rd_b;

  logic             s;
  logic             new_bit;
  logic             flip;
  decide_t          dec;

  assign cfg.ready = 1'b1;

  always_comb begin
    clearing      = (state == ST_CLEAR);
    exec_go       = (state == ST_EXEC) && (!result.valid || result.ready);
    request.ready = (state == ST_IDLE) || exec_go;
    accept        = request.valid && request.ready;

    req_row = MOD_TAB[request.row];
    req_up  = (req_row == '0) ? LAST_IDX : req_row - IW'(1);
    row_dn  = (row_q == LAST_IDX) ? '0 : row_q + IW'(1);
    col_l   = (col_q == '0) ? LAST_IDX : col_q - IW'(1);
    col_r   = (col_q == LAST_IDX) ? '0 : col_q + IW'(1);

    re_b    = accept || (state == ST_RD2);
    raddr_b = (state == ST_RD2) ? row_dn : req_up;

    s       = rd_a[col_q];
    flip    = (cmd_q == CMD_UPDATE) && dec.accept;
    new_bit = (cmd_q == CMD_UPDATE) ? (s ^ dec.accept) : spin_q;

    wrow        = rd_a;
    wrow[col_q] = new_bit;

    we    = clearing || exec_go;
    waddr = clearing ? clr_cnt : row_q;
    wdata = clearing ? '1 : wrow;

    mag_next = mag;
    if (new_bit != s) begin
      mag_next = new_bit ? (mag + MAG_STEP) : (mag - MAG_STEP);
    end

    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (request.cmd == CMD_UPDATE) ? ST_RD2 : ST_EXEC;
        end
      end
      ST_RD2: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (accept) begin
          state_next = (request.cmd == CMD_UPDATE) ? ST_RD2 : ST_EXEC;
        end else if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  isim_row_mem #(
    .SIDE (SIDE),
    .IW   (IW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (accept),
    .raddr_a (req_row),
    .rdata_a (rd_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  isim_decide u_decide (
    .s        (s),
    .left     (rd_a[col_l]),
    .right    (rd_a[col_r]),
    .up       (up_bit),
    .down     (rd_b[col_q]),
    .uniform  (uni_q),
    .th_four  (th_four),
    .th_eight (th_eight),
    .dec      (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      th_four      <= TH_FOUR_RESET;
      th_eight     <= TH_EIGHT_RESET;
      mag          <= MAG_RESET;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + IW'(1);
      end
      if (cfg.valid) begin
        case (cfg.index)
          REG_THRESH_FOUR:  th_four  <= cfg.data;
          REG_THRESH_EIGHT: th_eight <= cfg.data;
          default: begin
          end
        endcase
      end
      if (exec_go) begin
        mag          <= mag_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= request.cmd;
      row_q  <= req_row;
      col_q  <= MOD_TAB[request.col];
      spin_q <= request.spin_value;
      uni_q  <= request.uniform;
    end
    if (state == ST_RD2) begin
      up_bit <= rd_b[col_q];
    end
    if (exec_go) begin
      result.spin_after    <= new_bit;
      result.flipped       <= flip;
      result.energy_change <= (cmd_q == CMD_UPDATE) ? dec.de : DE_ZERO;
      result.magnetization <= signed'(mag_next);
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for ising_metropolis_spin_update: request driver, result
// monitor and an in-bench predictor of the spin lattice and magnetization.
// Depends on isim_pkg, isim_channels and the block's RTL.
`timescale 1ns / 1ps
module tb;
  import isim_pkg::*;

  localparam int SIDE        = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = '1;

  typedef struct packed {
    logic             cmd;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             spin_value;
    logic [UNI_W-1:0] uniform;
  } spin_req_t;

  typedef struct packed {
    logic                    spin_after;
    logic                    flipped;
    logic signed [DE_W-1:0]  de;
    logic signed [MAG_W-1:0] mag;
  } spin_res_t;

  logic clk = 1'b0;
  logic rst;

  isim_req_if req_ch ();
  isim_res_if res_ch ();
  isim_cfg_if cfg_ch ();

  ising_metropolis_spin_update #(.SIDE(SIDE)) dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lattice mirror: 1 is spin +1, 0 is spin -1
  bit           lattice [SIDE][SIDE];
  int unsigned  spin_sum;
  logic [TH_W-1:0] thr_four;
  logic [TH_W-1:0] thr_eight;

  spin_req_t pending_requests [$];
  spin_res_t expected_outcomes [$];
  int        mismatches;
  int        cycle_count;
  bit        steady;

  function automatic int spin_at(int r, int c);
    return lattice[r][c] ? 1 : -1;
  endfunction

  function automatic void set_spin(int r, int c, bit up);
    if (lattice[r][c] != up) begin
      spin_sum = up ? spin_sum + 2 : spin_sum - 2;
      lattice[r][c] = up;
    end
  endfunction

  function automatic spin_res_t metropolis_step(spin_req_t rq);
    int r;
    int c;
    int s;
    int nsum;
    logic signed [DE_W-1:0] de;
    bit take;
    spin_res_t o;
    r = int'(rq.row) % SIDE;
    c = int'(rq.col) % SIDE;
    de = DE_ZERO;
    take = 1'b0;
    if (rq.cmd == CMD_LOAD) begin
      set_spin(r, c, rq.spin_value);
    end else begin
      s = spin_at(r, c);
      nsum = spin_at(r, (c + 1) % SIDE) + spin_at(r, (c + SIDE - 1) % SIDE)
           + spin_at((r + SIDE - 1) % SIDE, c) + spin_at((r + 1) % SIDE, c);
      de = DE_W'(2 * s * nsum);
      if (de <= DE_ZERO)
        take = 1'b1;
      else if (de == DE_FOUR)
        take = rq.uniform < thr_four;
      else
        take = rq.uniform < thr_eight;
      if (take)
        set_spin(r, c, !lattice[r][c]);
    end
    o.spin_after = lattice[r][c];
    o.flipped    = take;
    o.de         = de;
    o.mag        = MAG_W'(spin_sum);
    return o;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // request driver: hold until accepted, then present the next pending request
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_outcomes.push_back(metropolis_step(pending_requests.pop_front()));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
          req_ch.valid      <= 1'b1;
          req_ch.cmd        <= pending_requests[0].cmd;
          req_ch.row        <= pending_requests[0].row;
          req_ch.col        <= pending_requests[0].col;
          req_ch.spin_value <= pending_requests[0].spin_value;
          req_ch.uniform    <= pending_requests[0].uniform;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    spin_res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result expected none got spin %0b mag %0d", $time,
                   res_ch.spin_after, res_ch.magnetization);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("spin_after", want.spin_after, res_ch.spin_after);
          check_field("flipped", want.flipped, res_ch.flipped);
          check_field("energy_change", want.de, res_ch.energy_change);
          check_field("magnetization", want.mag, res_ch.magnetization);
        end
      end
      res_ch.ready <= steady || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL ising_metropolis_spin_update");
      $finish;
    end
  end

  task automatic queue_request(logic cmd, logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                               logic spin_value, logic [UNI_W-1:0] uniform);
    pending_requests.push_back('{cmd, row, col, spin_value, uniform});
  endtask

  function automatic spin_req_t random_request(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] c0);
    spin_req_t q;
    q.cmd = ($urandom_range(99) < 35) ? CMD_LOAD : CMD_UPDATE;
    if ($urandom_range(99) < 80) begin
      q.row = ROW_W'(r0 + $urandom_range(2));
      q.col = ROW_W'(c0 + $urandom_range(2));
    end else begin
      q.row = ROW_W'($urandom);
      q.col = ROW_W'($urandom);
    end
    q.spin_value = 1'($urandom);
    case ($urandom_range(15))
      0:       q.uniform = '0;
      1:       q.uniform = '1;
      2:       q.uniform = thr_four;
      3:       q.uniform = thr_four - 1;
      4:       q.uniform = thr_eight;
      5:       q.uniform = thr_eight - 1;
      default: q.uniform = $urandom;
    endcase
    return q;
  endfunction

  // drain: wait until every request is accepted and every result has come
  task automatic drain();
    while (pending_requests.size() != 0 || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_THRESH_FOUR)
      thr_four = val;
    else if (idx == REG_THRESH_EIGHT)
      thr_eight = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // small windows, some across the wrap, so neighborhoods get mixed spins
  task automatic run_phase(int n);
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] c0;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        r0 = ($urandom_range(3) == 0) ? ROW_W'(SIDE - 2) : ROW_W'($urandom);
        c0 = ($urandom_range(3) == 0) ? ROW_W'(SIDE - 1) : ROW_W'($urandom);
      end
      pending_requests.push_back(random_request(r0, c0));
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_LOAD;
    req_ch.row = '0;
    req_ch.col = '0;
    req_ch.spin_value = 1'b0;
    req_ch.uniform = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    steady = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    foreach (lattice[r, c]) lattice[r][c] = 1'b1;
    spin_sum = SIDE * SIDE;
    thr_four = TH_FOUR_RESET;
    thr_eight = TH_EIGHT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // rise of eight: strict bound, then flip and flip back
    queue_request(CMD_UPDATE, 0, 0, 0, '1);
    queue_request(CMD_UPDATE, 0, 0, 0, TH_EIGHT_RESET);
    queue_request(CMD_UPDATE, 0, 0, 1, TH_EIGHT_RESET - 1);
    queue_request(CMD_UPDATE, 0, 0, 1, '1);
    // load down, reload same value
    queue_request(CMD_LOAD, 63, 63, 0, '1);
    queue_request(CMD_LOAD, 63, 63, 0, '0);
    // rise of four at a corner with wrapped neighbors, then drop of four
    queue_request(CMD_UPDATE, 0, 63, 0, '1);
    queue_request(CMD_UPDATE, 0, 63, 0, TH_FOUR_RESET);
    queue_request(CMD_UPDATE, 0, 63, 1, TH_FOUR_RESET - 1);
    queue_request(CMD_UPDATE, 0, 63, 0, '1);
    // zero change: flip both ways regardless of uniform
    queue_request(CMD_LOAD, 1, 63, 0, '1);
    queue_request(CMD_UPDATE, 0, 63, 0, '1);
    queue_request(CMD_UPDATE, 0, 63, 1, '1);
    queue_request(CMD_LOAD, 63, 63, 1, '0);
    queue_request(CMD_LOAD, 1, 63, 1, '1);
    queue_request(CMD_UPDATE, 63, 0, 0, '0);
    queue_request(CMD_LOAD, 63, 0, 1, '0);
    queue_request(CMD_UPDATE, 32, 17, 1, '0);
    queue_request(CMD_LOAD, 0, 0, 1, '1);
    drain();

    write_reg(REG_THRESH_FOUR, '0);
    write_reg(REG_THRESH_EIGHT, '0);
    run_phase(80);

    write_reg(REG_THRESH_FOUR, '1);
    write_reg(REG_THRESH_EIGHT, '1);
    run_phase(80);

    write_reg(REG_THRESH_FOUR, $urandom);
    write_reg(REG_THRESH_EIGHT, $urandom);
    write_reg(REG_SPARE_LOW, $urandom);
    write_reg(REG_SPARE_HIGH, $urandom);
    run_phase(80);

    write_reg(REG_THRESH_FOUR, $urandom);
    write_reg(REG_THRESH_EIGHT, $urandom_range(32'h3FFF_FFFF));
    steady = 1'b1;
    run_phase(120);
    steady = 1'b0;

    write_reg(REG_THRESH_FOUR, 32'd1);
    write_reg(REG_THRESH_EIGHT, 32'h8000_0000);
    run_phase(80);

    write_reg(REG_THRESH_FOUR, TH_FOUR_RESET);
    write_reg(REG_THRESH_EIGHT, TH_EIGHT_RESET);
    run_phase(60);

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("PASS ising_metropolis_spin_update");
    else
      $display("FAIL ising_metropolis_spin_update");
    $finish;
  end

endmodule
